// ===== hw/rtl/hsv_to_rgb565_gamma_top_assert.svh =====
// Assertion macros used by the HSV to RGB565 converter RTL.
`ifndef HSV_TO_RGB565_GAMMA_TOP_ASSERT_SVH
`define HSV_TO_RGB565_GAMMA_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define HSV565_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define HSV565_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hsv565_pkg.sv =====
// Types and constants for the HSV to RGB565 converter.
package hsv565_pkg;

  localparam int HUE_W   = 32;
  localparam int CHAN_W  = 8;
  localparam int NIB_W   = 4;
  localparam int COLOR_W = 16;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [2:0] {
    SEXT_RED_YEL  = 3'd0,
    SEXT_YEL_GRN  = 3'd1,
    SEXT_GRN_CYN  = 3'd2,
    SEXT_CYN_BLU  = 3'd3,
    SEXT_BLU_MAG  = 3'd4,
    SEXT_MAG_RED  = 3'd5
  } sextant_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NIB_W-1:0]  nib_t;

  // 8-bit scaled intensity to 4-bit gamma-corrected level
  localparam nib_t GAMMA_ROM [256] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3,
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9,
    4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11,
    4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd12, 4'd12,
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd13, 4'd13,
    4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd14, 4'd14, 4'd14,
    4'd14, 4'd14, 4'd14, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15
  };

endpackage

// ===== hw/rtl/hsv565_if.sv =====
// Valid/ready channels for HSV requests and RGB565 colors.
interface hsv565_hsv_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] hue;
  logic        [7:0]  sat;
  logic        [7:0]  val;
  logic               gamma_on;

  modport source (output valid, hue, sat, val, gamma_on, input ready);
  modport sink   (input valid, hue, sat, val, gamma_on, output ready);
endinterface

interface hsv565_rgb_if;
  logic        valid;
  logic        ready;
  logic [15:0] color565;

  modport source (output valid, color565, input ready);
  modport sink   (input valid, color565, output ready);
endinterface

// ===== hw/rtl/hsv_to_rgb565_gamma_top.sv =====
// HSV to RGB565 converter: five-stage pipeline with optional gamma lookup.
//
// Accepts one HSV beat per clock unless the sink stalls, and returns one RGB565 beat
// per request, in order. The whole pipeline advances together whenever the output
// register is empty or being taken, so throughput is one beat per cycle and a
// stalled sink freezes every stage in place. Stages: hue residue sum, sextant
// and channel mix, saturation multiply, value multiply, gamma ROM or linear shift
// and pack. The hue wraps every 1536 steps, negative values included.
`include "hsv_to_rgb565_gamma_top_assert.svh"

module hsv_to_rgb565_gamma_top (
  input  logic         clk,
  input  logic         rst,
  hsv565_hsv_if.sink   hsv,
  hsv565_rgb_if.source rgb
);
  import hsv565_pkg::*;

  logic adv;

  // stage 1: residue of hue/512 mod 3 as a digit sum, low 9 hue bits
  logic       v1;
  logic [6:0] dsum1;
  logic [8:0] lo9_1;
  chan_t      sat1, val1;
  logic       gam1;
  logic [6:0] dsum_next;

  // stage 2: channels before saturation
  logic     v2;
  chan_t    r2, g2, b2;
  chan_t    sat2, val2;
  logic     gam2;
  logic [3:0] psum;
  logic [1:0] mod3;
  sextant_t sext;
  chan_t    lo;
  chan_t    r_mix, g_mix, b_mix;

  // stage 3: after saturation
  logic  v3;
  chan_t r3, g3, b3;
  chan_t val3;
  logic  gam3;

  // stage 4: top byte of value product
  logic  v4;
  chan_t r4, g4, b4;
  logic  gam4;

  nib_t rn, gn, bn;

  assign adv       = !rgb.valid || rgb.ready;
  assign hsv.ready = adv;

  // bits of hue>>>9 grouped by weight 16^k (each 1 mod 3); sign bit weighs 2 mod 3
  assign dsum_next = 7'(hsv.hue[12:9]) + 7'(hsv.hue[16:13]) + 7'(hsv.hue[20:17])
                   + 7'(hsv.hue[24:21]) + 7'(hsv.hue[28:25]) + 7'(hsv.hue[30:29])
                   + (hsv.hue[31] ? 7'd2 : 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= hsv.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dsum1 <= dsum_next;
      lo9_1 <= hsv.hue[8:0];
      sat1  <= hsv.sat;
      val1  <= hsv.val;
      gam1  <= hsv.gamma_on;
    end
  end

  always_comb begin
    psum = 4'(dsum1[1:0]) + 4'(dsum1[3:2]) + 4'(dsum1[5:4]) + 4'(dsum1[6]);
    priority if (psum >= 4'd9) begin
      mod3 = 2'(psum - 4'd9);
    end else if (psum >= 4'd6) begin
      mod3 = 2'(psum - 4'd6);
    end else if (psum >= 4'd3) begin
      mod3 = 2'(psum - 4'd3);
    end else begin
      mod3 = psum[1:0];
    end
  end

  assign sext = sextant_t'({mod3, lo9_1[8]});
  assign lo   = lo9_1[7:0];

  always_comb begin
    unique case (sext)
      SEXT_RED_YEL: begin
        r_mix = CHAN_MAX;      g_mix = lo;            b_mix = '0;
      end
      SEXT_YEL_GRN: begin
        r_mix = CHAN_MAX - lo; g_mix = CHAN_MAX;      b_mix = '0;
      end
      SEXT_GRN_CYN: begin
        r_mix = '0;            g_mix = CHAN_MAX;      b_mix = lo;
      end
      SEXT_CYN_BLU: begin
        r_mix = '0;            g_mix = CHAN_MAX - lo; b_mix = CHAN_MAX;
      end
      SEXT_BLU_MAG: begin
        r_mix = lo;            g_mix = '0;            b_mix = CHAN_MAX;
      end
      default: begin
        r_mix = CHAN_MAX;      g_mix = '0;            b_mix = CHAN_MAX - lo;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r2   <= r_mix;
      g2   <= g_mix;
      b2   <= b_mix;
      sat2 <= sat1;
      val2 <= val1;
      gam2 <= gam1;
    end
  end

  // saturation: 255 - ((255 - c) * (sat + 1)) >> 8
  logic [8:0]  s_plus1;
  logic [16:0] rs_prod, gs_prod, bs_prod;

  assign s_plus1 = 9'(sat2) + 9'd1;
  assign rs_prod = 17'(CHAN_MAX - r2) * 17'(s_plus1);
  assign gs_prod = 17'(CHAN_MAX - g2) * 17'(s_plus1);
  assign bs_prod = 17'(CHAN_MAX - b2) * 17'(s_plus1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r3   <= CHAN_MAX - rs_prod[15:8];
      g3   <= CHAN_MAX - gs_prod[15:8];
      b3   <= CHAN_MAX - bs_prod[15:8];
      val3 <= val2;
      gam3 <= gam2;
    end
  end

  // value scaling; product never exceeds 16 bits
  logic [8:0]  v_plus1;
  logic [16:0] rv_prod, gv_prod, bv_prod;

  assign v_plus1 = 9'(val3) + 9'd1;
  assign rv_prod = 17'(r3) * 17'(v_plus1);
  assign gv_prod = 17'(g3) * 17'(v_plus1);
  assign bv_prod = 17'(b3) * 17'(v_plus1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4   <= rv_prod[15:8];
      g4   <= gv_prod[15:8];
      b4   <= bv_prod[15:8];
      gam4 <= gam3;
    end
  end

  always_comb begin
    if (gam4) begin
      rn = GAMMA_ROM[r4];
      gn = GAMMA_ROM[g4];
      bn = GAMMA_ROM[b4];
    end else begin
      rn = r4[7:4];
      gn = g4[7:4];
      bn = b4[7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb.valid <= 1'b0;
    end else if (adv) begin
      rgb.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb.color565 <= {rn, rn[3], gn, gn[3:2], bn, bn[3]};
    end
  end

  `HSV565_ASSERT_IMP(a_mix_has_full_and_zero, v2,
    (r2 == CHAN_MAX || g2 == CHAN_MAX || b2 == CHAN_MAX) &&
    (r2 == '0 || g2 == '0 || b2 == '0),
    "hue mix lacks a full or an empty channel")
  `HSV565_ASSERT_IMP(a_pack_replicates_msbs, rgb.valid,
    (rgb.color565[11] == rgb.color565[15]) &&
    (rgb.color565[6:5] == rgb.color565[10:9]) &&
    (rgb.color565[0] == rgb.color565[4]),
    "RGB565 widening bits do not repeat the top bits")
  `HSV565_ASSERT_NXT(a_reset_empties_pipe, rst,
    !v1 && !v2 && !v3 && !v4 && !rgb.valid,
    "pipeline holds a valid beat after reset")

endmodule

// ===== test/hsv_to_rgb565_gamma_top_test.sv =====
// Self-checking testbench for the HSV to RGB565 converter with gamma lookup.
`timescale 1ns / 1ps

module hsv_to_rgb565_gamma_top_test;
  import hsv565_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 11;
  localparam int RAND_REQS   = 1350;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 12;

  typedef struct {
    logic signed [HUE_W-1:0] hue;
    logic [CHAN_W-1:0]       sat;
    logic [CHAN_W-1:0]       val;
    logic                    gamma_on;
    bit                      drain_first;  // hold this beat until the pipe is empty
  } hsv_req_t;

  // 8-bit scaled intensity to 4-bit level
  localparam bit [3:0] GAMMA_LUT [256] = '{
    0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,1,1,1,1,1,1, 1,1,1,1,1,1,1,1, 1,1,1,1,1,1,1,1, 1,1,1,1,1,1,1,1,
    1,1,1,1,1,1,2,2, 2,2,2,2,2,2,2,2, 2,2,2,2,2,2,2,2, 2,2,2,2,2,3,3,3,
    3,3,3,3,3,3,3,3, 3,3,3,3,3,3,3,4, 4,4,4,4,4,4,4,4, 4,4,4,4,4,4,5,5,
    5,5,5,5,5,5,5,5, 5,5,5,6,6,6,6,6, 6,6,6,6,6,6,6,7, 7,7,7,7,7,7,7,7,
    7,7,8,8,8,8,8,8, 8,8,8,8,9,9,9,9, 9,9,9,9,9,10,10,10, 10,10,10,10,10,10,11,11,
    11,11,11,11,11,11,12,12, 12,12,12,12,12,12,13,13, 13,13,13,13,13,14,14,14,
    14,14,14,14,15,15,15,15
  };

  logic clk;
  logic rst;

  hsv565_hsv_if hsv_ch ();
  hsv565_rgb_if rgb_ch ();

  hsv_to_rgb565_gamma_top dut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv_ch),
    .rgb (rgb_ch)
  );

  hsv_req_t          pending_reqs [$];
  logic [COLOR_W-1:0] expected_colors [$];

  bit in_taken;
  bit out_taken;
  int gap_left;
  int stall_left;
  int in_burst;
  int out_burst;
  int fails;
  int cycle_count;

  always #(CLK_HALF) clk = ~clk;

  // Saturation then value scaling of one 8-bit channel, down to 4 bits.
  function automatic logic [NIB_W-1:0] scale_chan(logic [7:0] c, logic [7:0] s,
                                                  logic [7:0] v, logic use_lut);
    int unsigned desat;
    logic [15:0] lvl;
    desat = 255 - (((255 - c) * (s + 1)) >> 8);
    lvl   = 16'(desat * (v + 1));
    return use_lut ? GAMMA_LUT[lvl[15:8]] : lvl[15:12];
  endfunction

  function automatic logic [COLOR_W-1:0] hsv_to_565(hsv_req_t r);
    int hue_i;
    int wheel;
    logic [7:0] mix;
    logic [7:0] chan [3];
    logic [NIB_W-1:0] nib [3];
    hue_i = r.hue;
    wheel = hue_i % 1536;  // truncates toward zero
    if (wheel < 0) wheel += 1536;
    mix = wheel[7:0];
    case (sextant_t'(wheel[10:8]))
      SEXT_RED_YEL: chan = '{CHAN_MAX, mix, 8'd0};
      SEXT_YEL_GRN: chan = '{CHAN_MAX - mix, CHAN_MAX, 8'd0};
      SEXT_GRN_CYN: chan = '{8'd0, CHAN_MAX, mix};
      SEXT_CYN_BLU: chan = '{8'd0, CHAN_MAX - mix, CHAN_MAX};
      SEXT_BLU_MAG: chan = '{mix, 8'd0, CHAN_MAX};
      default:      chan = '{CHAN_MAX, 8'd0, CHAN_MAX - mix};
    endcase
    for (int i = 0; i < 3; i++) nib[i] = scale_chan(chan[i], r.sat, r.val, r.gamma_on);
    return {nib[0], nib[0][3], nib[1], nib[1][3:2], nib[2], nib[2][3]};
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch of none.
  function automatic int pick_gap(inout int burst);
    int roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_req(int hue, int sat, int val, bit gamma_on, bit drain_first);
    hsv_req_t r;
    r.hue         = hue;
    r.sat         = sat[7:0];
    r.val         = val[7:0];
    r.gamma_on    = gamma_on;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endtask

  function automatic int rand_level();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic int rand_hue();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return int'($urandom);
    if (roll < 8) return $urandom_range(0, 1535);
    return -int'($urandom_range(1, 5000));
  endfunction

  // Sender: a new beat goes out once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      hsv_ch.valid <= 1'b0;
    end else if (!hsv_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        hsv_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && expected_colors.size() != 0)) begin
        hsv_ch.hue      <= pending_reqs[0].hue;
        hsv_ch.sat      <= pending_reqs[0].sat;
        hsv_ch.val      <= pending_reqs[0].val;
        hsv_ch.gamma_on <= pending_reqs[0].gamma_on;
        hsv_ch.valid    <= 1'b1;
        void'(pending_reqs.pop_front());
        gap_left = pick_gap(in_burst);
      end else begin
        hsv_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls after some beats and at random while waiting.
  always @(negedge clk) begin
    if (rst) begin
      rgb_ch.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken  = 1'b0;
        stall_left = pick_gap(out_burst);
      end else if (stall_left == 0 && out_burst == 0 && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        rgb_ch.ready <= 1'b0;
      end else begin
        rgb_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    logic [COLOR_W-1:0] want;
    hsv_req_t seen;
    if (!rst && hsv_ch.valid && hsv_ch.ready) begin
      seen.hue         = hsv_ch.hue;
      seen.sat         = hsv_ch.sat;
      seen.val         = hsv_ch.val;
      seen.gamma_on    = hsv_ch.gamma_on;
      seen.drain_first = 1'b0;
      expected_colors.push_back(hsv_to_565(seen));
      in_taken = 1'b1;
    end
    if (!rst && rgb_ch.valid && rgb_ch.ready) begin
      out_taken = 1'b1;
      if (expected_colors.size() == 0) begin
        $error("color565: beat with nothing expected, actual %h", rgb_ch.color565);
        fails++;
      end else begin
        want = expected_colors.pop_front();
        if (rgb_ch.color565 !== want) begin
          $error("color565: expected %h, actual %h", want, rgb_ch.color565);
          fails++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    hsv_ch.valid    = 1'b0;
    hsv_ch.hue      = '0;
    hsv_ch.sat      = '0;
    hsv_ch.val      = '0;
    hsv_ch.gamma_on = 1'b0;
    rgb_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    out_taken       = 1'b0;
    gap_left        = 0;
    stall_left      = 0;
    in_burst        = 0;
    out_burst       = 0;
    fails           = 0;

    // directed: sextants, wrap points, extreme hues, sat/val corners
    add_req(0,            255, 255, 1'b0, 1'b0);
    add_req(0,            255, 255, 1'b1, 1'b0);
    add_req(255,          255, 255, 1'b1, 1'b0);
    add_req(384,          255, 255, 1'b0, 1'b0);
    add_req(640,          255, 255, 1'b1, 1'b0);
    add_req(896,          255, 255, 1'b0, 1'b0);
    add_req(1152,         255, 255, 1'b1, 1'b0);
    add_req(1408,         255, 255, 1'b0, 1'b0);
    add_req(1535,         255, 255, 1'b1, 1'b0);
    add_req(1536,         255, 255, 1'b0, 1'b0);
    add_req(-1,           255, 255, 1'b1, 1'b0);
    add_req(-1536,        255, 255, 1'b0, 1'b0);
    add_req(-1537,        255, 255, 1'b1, 1'b0);
    add_req(32'h7fffffff, 255, 255, 1'b0, 1'b0);
    add_req(32'h80000000, 255, 255, 1'b1, 1'b0);
    add_req(32'h80000000, 170, 90,  1'b0, 1'b0);
    add_req(700,          0,   255, 1'b0, 1'b0);  // no saturation: white
    add_req(700,          0,   255, 1'b1, 1'b0);
    add_req(1000,         0,   0,   1'b1, 1'b0);
    add_req(300,          255, 0,   1'b0, 1'b0);
    add_req(300,          128, 128, 1'b1, 1'b0);
    add_req(1200,         1,   254, 1'b0, 1'b0);
    add_req(-769,         200, 100, 1'b1, 1'b0);

    for (int i = 0; i < RAND_REQS; i++)
      add_req(rand_hue(), rand_level(), rand_level(), $urandom_range(0, 1),
              (i % 200) == 100);

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || hsv_ch.valid) @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hsv565_pkg.sv
hw/rtl/hsv565_if.sv
hw/rtl/hsv_to_rgb565_gamma_top.sv
test/hsv_to_rgb565_gamma_top_test.sv
